>>> src/mrt_pkg.sv
package mrt_pkg;

	// Operand and register geometry.
	localparam int WordW    = 32;
	localparam int NumCols  = 4;
	localparam int NumRegs  = 8;
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 64;

	// Accumulation widths: one product, a pair of products, all four products.
	localparam int ProdW = 2 * WordW;
	localparam int PairW = ProdW + 1;
	localparam int SumW  = ProdW + 2;

	// Default fraction width of the fixed-point format.
	localparam int FracBitsDefault = 16;

	typedef logic signed [WordW-1:0] word_t;
	typedef word_t row_t [NumCols];
	typedef logic signed [SumW-1:0] sum_t;
	typedef sum_t sum_row_t [NumCols];

	// Reset contents of the coefficient registers: the identity matrix.
	localparam logic [CfgDataW-1:0] CoefReset [NumRegs] = '{
		64'h0000_0000_0001_0000,
		64'h0000_0000_0000_0000,
		64'h0001_0000_0000_0000,
		64'h0000_0000_0000_0000,
		64'h0000_0000_0000_0000,
		64'h0000_0000_0001_0000,
		64'h0000_0000_0000_0000,
		64'h0001_0000_0000_0000
	};

endpackage

>>> src/mrt_lane.sv
module mrt_lane (
	input  logic           clk,
	input  logic           advance,
	input  mrt_pkg::row_t  left,
	input  mrt_pkg::row_t  coef,
	output mrt_pkg::sum_t  sum_s3
);
	import mrt_pkg::*;

	logic signed [ProdW-1:0] prod_s1 [NumCols];
	logic signed [PairW-1:0] pair_s2 [2];

	// Stage 1: one product per left element and matrix entry of this column.
	always_ff @(posedge clk) begin
		if (advance) begin
			for (int k = 0; k < NumCols; k++) begin
				prod_s1[k] <= ProdW'(left[k]) * ProdW'(coef[k]);
			end
		end
	end

	// Stage 2: sum the products in pairs.
	always_ff @(posedge clk) begin
		if (advance) begin
			pair_s2[0] <= PairW'(prod_s1[0]) + PairW'(prod_s1[1]);
			pair_s2[1] <= PairW'(prod_s1[2]) + PairW'(prod_s1[3]);
		end
	end

	// Stage 3: the exact dot product of the row with this column.
	always_ff @(posedge clk) begin
		if (advance) begin
			sum_s3 <= SumW'(pair_s2[0]) + SumW'(pair_s2[1]);
		end
	end

endmodule

>>> src/mrt_merge.sv
module mrt_merge #(
	parameter int FRAC_BITS = mrt_pkg::FracBitsDefault
) (
	input  logic              clk,
	input  logic              advance,
	input  mrt_pkg::sum_row_t sum_s3,
	output mrt_pkg::row_t     result_q,
	output logic              saturated_q
);
	import mrt_pkg::*;

	localparam int ShW = SumW - FRAC_BITS;
	localparam sum_t Rnd = sum_t'(SumW'(1) << (FRAC_BITS - 1));

	sum_t             rounded [NumCols];
	logic [ShW-1:0]   shifted [NumCols];
	logic [NumCols-1:0] clamp;
	word_t            sat_word [NumCols];

	// Round to nearest, drop the fraction bits and clamp each column to 32 bits.
	always_comb begin
		for (int j = 0; j < NumCols; j++) begin
			rounded[j] = sum_s3[j] + Rnd;
			shifted[j] = rounded[j][SumW-1:FRAC_BITS];
			if (!shifted[j][ShW-1] && (|shifted[j][ShW-2:WordW-1])) begin
				clamp[j]    = 1'b1;
				sat_word[j] = {1'b0, {(WordW-1){1'b1}}};
			end else if (shifted[j][ShW-1] && !(&shifted[j][ShW-2:WordW-1])) begin
				clamp[j]    = 1'b1;
				sat_word[j] = {1'b1, {(WordW-1){1'b0}}};
			end else begin
				clamp[j]    = 1'b0;
				sat_word[j] = shifted[j][WordW-1:0];
			end
		end
	end

	// Output register: the four columns and the combined clamp flag.
	always_ff @(posedge clk) begin
		if (advance) begin
			for (int j = 0; j < NumCols; j++) begin
				result_q[j] <= sat_word[j];
			end
			saturated_q <= |clamp;
		end
	end

endmodule

>>> src/matrix_row_transform_4x4.sv
// Channel  Handshake           Word
// input    in_valid/in_ready   left_elem_0..3, signed Q16.16
// output   out_valid/out_ready result_elem_0..3, saturated
// config   cfg_we              cfg_index (0..7), cfg_data (64 bits)
//
// One row is taken every cycle while the output does not stall. Each row passes the
// lanes' multiply, pair-sum and total registers and then the rounding output register.
// When a result waits and out_ready is low the whole pipeline holds.
// Reset clears the pipeline valid bits and loads the identity matrix.
module matrix_row_transform_4x4 #(
	parameter int FRAC_BITS = mrt_pkg::FracBitsDefault
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [mrt_pkg::WordW-1:0] left_elem_0,
	input  logic signed [mrt_pkg::WordW-1:0] left_elem_1,
	input  logic signed [mrt_pkg::WordW-1:0] left_elem_2,
	input  logic signed [mrt_pkg::WordW-1:0] left_elem_3,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [mrt_pkg::WordW-1:0] result_elem_0,
	output logic signed [mrt_pkg::WordW-1:0] result_elem_1,
	output logic signed [mrt_pkg::WordW-1:0] result_elem_2,
	output logic signed [mrt_pkg::WordW-1:0] result_elem_3,
	output logic                          saturated,
	input  logic                          cfg_we,
	input  logic [mrt_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [mrt_pkg::CfgDataW-1:0]  cfg_data
);
	import mrt_pkg::*;

	logic [CfgDataW-1:0] coef_q [NumRegs];
	logic     advance;
	logic     valid_s1, valid_s2, valid_s3, out_valid_q;
	row_t     left;
	row_t     coef_col [NumCols];
	sum_row_t sum_s3;
	row_t     result_q;
	logic     saturated_q;

	// Coefficient registers, written by index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= CoefReset;
		end else if (cfg_we) begin
			coef_q[cfg_index] <= cfg_data;
		end
	end

	// Column j of the matrix: entry k sits in register 2k + j/2, half j%2.
	always_comb begin
		for (int j = 0; j < NumCols; j++) begin
			for (int k = 0; k < NumCols; k++) begin
				if (j % 2 == 1) begin
					coef_col[j][k] = coef_q[CfgIdxW'(2 * k + j / 2)][CfgDataW-1:WordW];
				end else begin
					coef_col[j][k] = coef_q[CfgIdxW'(2 * k + j / 2)][WordW-1:0];
				end
			end
		end
	end

	assign left[0] = left_elem_0;
	assign left[1] = left_elem_1;
	assign left[2] = left_elem_2;
	assign left[3] = left_elem_3;

	// The pipeline moves unless a finished word waits at the output.
	assign advance  = !out_valid_q || out_ready;
	assign in_ready = advance;

	// Valid bits that travel with each row.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			valid_s1    <= in_valid;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			out_valid_q <= valid_s3;
		end
	end

	// One lane per result column.
	for (genvar j = 0; j < NumCols; j++) begin : g_lane
		mrt_lane u_lane (
			.clk     (clk),
			.advance (advance),
			.left    (left),
			.coef    (coef_col[j]),
			.sum_s3  (sum_s3[j])
		);
	end

	// Rounding, clamping and the output register.
	mrt_merge #(
		.FRAC_BITS (FRAC_BITS)
	) u_merge (
		.clk         (clk),
		.advance     (advance),
		.sum_s3      (sum_s3),
		.result_q    (result_q),
		.saturated_q (saturated_q)
	);

	assign out_valid     = out_valid_q;
	assign result_elem_0 = result_q[0];
	assign result_elem_1 = result_q[1];
	assign result_elem_2 = result_q[2];
	assign result_elem_3 = result_q[3];
	assign saturated     = saturated_q;

	// A raised clamp flag means at least one column sits at a limit.
	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |->
			(result_elem_0 == 32'sh7FFF_FFFF) || (result_elem_0 == 32'sh8000_0000) ||
			(result_elem_1 == 32'sh7FFF_FFFF) || (result_elem_1 == 32'sh8000_0000) ||
			(result_elem_2 == 32'sh7FFF_FFFF) || (result_elem_2 == 32'sh8000_0000) ||
			(result_elem_3 == 32'sh7FFF_FFFF) || (result_elem_3 == 32'sh8000_0000))
		else $error("clamp flag set with no column at a limit");

	// A result word leaves only when it was taken.
	a_out_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(out_ready))
		else $error("result word dropped without handshake");

	// While the output stalls, rows in flight hold their place.
	a_hold_s3: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready && valid_s3 |=> valid_s3 && out_valid)
		else $error("pipeline moved during an output stall");

	// A stage fills only from the stage before it.
	a_fill_s2: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_s2) |-> $past(valid_s1))
		else $error("stage 2 filled without a row in stage 1");

endmodule

>>> tb/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import mrt_pkg::*;

	localparam int FracBits     = FracBitsDefault;
	localparam int PipeLatency  = 4;
	localparam int RandPhases   = 10;
	localparam int RowsPerPhase = 170;
	localparam int LongHold     = 200;
	localparam longint TimeLimitNs = 5_000_000;

	typedef struct packed {
		logic [NumCols-1:0][WordW-1:0] elem;
		logic                          sat;
	} row_result_t;

	typedef enum int {
		MatSmall,
		MatFull,
		MatCorner
	} matrix_kind_t;

	// Holds its own copy of the coefficient matrix, predicts each row product and
	// keeps the predicted rows in arrival order.
	class row_scoreboard;
		logic [CfgDataW-1:0] coef [NumRegs];
		row_result_t         pending [$];
		int unsigned         rows_checked;
		int unsigned         sat_rows;
		int unsigned         errors;

		function new();
			foreach (coef[i])
				coef[i] = CoefReset[i];
		endfunction

		function void write_coef(int unsigned idx, logic [CfgDataW-1:0] data);
			if (idx < NumRegs)
				coef[idx] = data;
		endfunction

		// Element M[row][col]: each register holds two adjacent columns of a row.
		function word_t coef_elem(int unsigned row, int unsigned col);
			logic [CfgDataW-1:0] r;
			r = coef[row * 2 + col / 2];
			return (col % 2) ? r[63:32] : r[31:0];
		endfunction

		// Exact wide sum of four products, rounded half up, shifted and clamped.
		function row_result_t transform(row_t lrow);
			logic signed [79:0] acc;
			logic signed [79:0] a;
			logic signed [79:0] b;
			row_result_t        res;
			res = '0;
			for (int j = 0; j < NumCols; j++) begin
				acc = '0;
				for (int k = 0; k < NumCols; k++) begin
					a   = lrow[k];
					b   = coef_elem(k, j);
					acc = acc + a * b;
				end
				acc = acc + (80'sd1 <<< (FracBits - 1));
				acc = acc >>> FracBits;
				if (acc > 80'sh7FFF_FFFF) begin
					res.elem[j] = 32'h7FFF_FFFF;
					res.sat     = 1'b1;
				end else if (acc < ~80'sh7FFF_FFFF) begin
					res.elem[j] = 32'h8000_0000;
					res.sat     = 1'b1;
				end else begin
					res.elem[j] = acc[WordW-1:0];
				end
			end
			return res;
		endfunction

		function void note_row(row_t lrow);
			row_result_t e;
			e = transform(lrow);
			if (e.sat)
				sat_rows++;
			pending.push_back(e);
		endfunction

		function void report(string what, logic [WordW-1:0] e, logic [WordW-1:0] g);
			errors++;
			$display("%0d ns  %s mismatch: expected %h, actual %h", $time, what, e, g);
		endfunction

		function void check_row(row_result_t got);
			row_result_t e;
			if (pending.size() == 0) begin
				errors++;
				$display("%0d ns  result word with nothing expected: %h", $time, got);
				return;
			end
			e = pending.pop_front();
			rows_checked++;
			for (int j = 0; j < NumCols; j++) begin
				if (got.elem[j] !== e.elem[j])
					report($sformatf("result_elem_%0d", j), e.elem[j], got.elem[j]);
			end
			if (got.sat !== e.sat)
				report("saturated", 32'(e.sat), 32'(got.sat));
		endfunction
	endclass

	bit clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	word_t left_elem_0, left_elem_1, left_elem_2, left_elem_3;
	logic out_valid;
	logic out_ready;
	word_t result_elem_0, result_elem_1, result_elem_2, result_elem_3;
	logic saturated;
	logic cfg_we;
	logic [CfgIdxW-1:0] cfg_index;
	logic [CfgDataW-1:0] cfg_data;

	row_scoreboard sb = new();

	bit jitter_on = 1'b1;
	bit hold_req  = 1'b0;
	int unsigned settings_loaded = 0;

	always #6 clk = ~clk;

	matrix_row_transform_4x4 #(
		.FRAC_BITS(FracBits)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.left_elem_0  (left_elem_0),
		.left_elem_1  (left_elem_1),
		.left_elem_2  (left_elem_2),
		.left_elem_3  (left_elem_3),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_elem_0(result_elem_0),
		.result_elem_1(result_elem_1),
		.result_elem_2(result_elem_2),
		.result_elem_3(result_elem_3),
		.saturated    (saturated),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// A value drawn from one of three families: full range, small magnitude, corners.
	function automatic word_t rand_word(int unsigned family);
		word_t w;
		int unsigned sh;
		case (family)
			0: w = $urandom();
			1: begin
				sh = $urandom_range(4, 22);
				w  = $urandom();
				w  = w >>> (31 - sh);
			end
			default: begin
				case ($urandom_range(0, 7))
					0: w = 32'h0000_0000;
					1: w = 32'h0000_0001;
					2: w = 32'hFFFF_FFFF;
					3: w = 32'h0001_0000;
					4: w = 32'hFFFF_0000;
					5: w = 32'h7FFF_FFFF;
					6: w = 32'h8000_0000;
					default: w = 32'h0000_8000;
				endcase
			end
		endcase
		return w;
	endfunction

	function automatic word_t rand_left();
		int unsigned r;
		r = $urandom_range(0, 99);
		return rand_word(r < 60 ? 1 : (r < 85 ? 0 : 2));
	endfunction

	function automatic word_t rand_coef(matrix_kind_t kind);
		case (kind)
			MatSmall: return rand_word(1);
			MatFull:  return rand_word(0);
			default:  return rand_word($urandom_range(0, 2));
		endcase
	endfunction

	// Present one row and hold it until the block takes the word.
	task automatic send_row(row_t lrow);
		in_valid    <= 1'b1;
		left_elem_0 <= lrow[0];
		left_elem_1 <= lrow[1];
		left_elem_2 <= lrow[2];
		left_elem_3 <= lrow[3];
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_row(lrow);
	endtask

	task automatic send_fixed(word_t w0, word_t w1, word_t w2, word_t w3);
		row_t lrow;
		lrow = '{w0, w1, w2, w3};
		send_row(lrow);
	endtask

	// Sender gap of a random length, only while idling is enabled.
	task automatic maybe_gap();
		if (jitter_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
	endtask

	// Stop sending and wait until every predicted row has come back.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
	endtask

	// Registers are only written with the pipeline empty.
	task automatic load_matrix(logic [CfgDataW-1:0] m [NumRegs]);
		drain();
		repeat (PipeLatency + 2) @(posedge clk);
		for (int i = 0; i < NumRegs; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= CfgIdxW'(i);
			cfg_data  <= m[i];
			@(posedge clk);
			sb.write_coef(i, m[i]);
		end
		cfg_we <= 1'b0;
		settings_loaded++;
	endtask

	task automatic load_uniform(word_t v);
		logic [CfgDataW-1:0] m [NumRegs];
		foreach (m[i])
			m[i] = {v, v};
		load_matrix(m);
	endtask

	task automatic load_random(matrix_kind_t kind);
		logic [CfgDataW-1:0] m [NumRegs];
		foreach (m[i])
			m[i] = {rand_coef(kind), rand_coef(kind)};
		load_matrix(m);
	endtask

	// Result monitor: every accepted word is checked against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_row('{elem: {result_elem_3, result_elem_2, result_elem_1, result_elem_0},
				sat: saturated});
	end

	// Receiver: random stalls, stretches of steady acceptance and one long hold-off.
	initial begin
		out_ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (LongHold) @(posedge clk);
				hold_req = 1'b0;
			end else if (jitter_on && $urandom_range(0, 4) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	// Overall time limit.
	initial begin
		#(TimeLimitNs);
		$display("Timed out with %0d rows still awaited.", sb.pending.size());
		$display("[matrix_row_transform_4x4] ERROR");
		$finish;
	end

	// Stimulus.
	initial begin
		row_t lrow;
		arst_n       = 1'b0;
		in_valid    <= 1'b0;
		left_elem_0 <= '0;
		left_elem_1 <= '0;
		left_elem_2 <= '0;
		left_elem_3 <= '0;
		cfg_we      <= 1'b0;
		cfg_index   <= '0;
		cfg_data    <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Identity matrix from reset: extremes pass straight through.
		send_fixed(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		send_fixed(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001);
		send_fixed(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
		send_fixed(32'h0000_8000, 32'hFFFF_8000, 32'h0001_0000, 32'hFFFF_0000);

		// Largest coefficients: overflow in both directions.
		load_uniform(32'h7FFF_FFFF);
		send_fixed(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_fixed(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_fixed(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		send_fixed(32'h0000_0001, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);

		// Most negative coefficients: the product of two minima is the widest sum.
		load_uniform(32'h8000_0000);
		send_fixed(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_fixed(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_fixed(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);

		// Smallest step everywhere: halves round up, towards plus infinity.
		load_uniform(32'h0000_0001);
		send_fixed(32'h0000_8000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		send_fixed(32'hFFFF_8000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		send_fixed(32'hFFFF_7FFF, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		send_fixed(32'h0000_7FFF, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);

		// All ones: sums land exactly on and just past the 32-bit limits.
		load_uniform(32'h0001_0000);
		send_fixed(32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		send_fixed(32'h7FFF_FFFF, 32'h0000_0001, 32'h0000_0000, 32'h0000_0000);
		send_fixed(32'h8000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		send_fixed(32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);

		// Random rows under a sequence of random matrices; the last phases run flat out.
		for (int p = 0; p < RandPhases; p++) begin
			load_random(matrix_kind_t'(p % 3));
			jitter_on = (p < RandPhases - 2);
			for (int n = 0; n < RowsPerPhase; n++) begin
				foreach (lrow[k])
					lrow[k] = rand_left();
				send_row(lrow);
				if (p == 2 && n == 40)
					hold_req = 1'b1;
				if (p == 4 && n == 80)
					drain();
				else
					maybe_gap();
			end
		end

		drain();
		repeat (PipeLatency * 4) @(posedge clk);

		$display("Checked %0d result rows (%0d saturated) under %0d coefficient settings.",
			sb.rows_checked, sb.sat_rows, settings_loaded + 1);
		$display("Covered reset identity, extreme and unit matrices, rounding ties and stalls.");
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("[matrix_row_transform_4x4] OK");
		end else begin
			$display("%0d mismatches, %0d rows missing.", sb.errors, sb.pending.size());
			$display("[matrix_row_transform_4x4] ERROR");
		end
		$finish;
	end

endmodule

>>> filelist.f
src/mrt_pkg.sv
src/mrt_lane.sv
src/mrt_merge.sv
src/matrix_row_transform_4x4.sv
tb/tb_top.sv
